// ----- design/circ_pkg.sv -----
// ----------------------------------------------------------------------------
// circ_pkg
// Widths, beat types and shared datapath steps for the tetrahedron
// circumsphere pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package circ_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 16;
  localparam int QW          = 48;

  localparam int CW   = COORD_WIDTH;
  localparam int EW   = CW + 1;              // edge vector
  localparam int XW   = 2 * EW + 1;          // cross product
  localparam int LW   = 2 * EW;              // squared edge length
  localparam int DW   = EW + XW + 2;         // triple product
  localparam int DNW  = DW + 1;              // 2*|det|
  localparam int PW   = XW + LW + 1;         // weighted cross term
  localparam int NW   = PW + 2;              // offset numerator N
  localparam int NUMW = NW + FRAC_BITS + 1;  // center dividend
  localparam int CHW  = 24;
  localparam int NCH  = (NW + CHW - 1) / CHW;
  localparam int CPW  = CHW * NCH;
  localparam int SQW  = 2 * CPW;
  localparam int SW   = SQW + 2;             // |N|^2
  localparam int XOW  = SW + 2 * FRAC_BITS;  // root operand
  localparam int RTW  = XOW / 2;             // root
  localparam int RMW  = RTW + 2;             // root remainder
  localparam int RQW  = DNW + QW;            // divider {rem, quotient}
  localparam int AW   = CW + FRAC_BITS;
  localparam int UW   = ((AW > QW) ? AW : QW) + 2;

  localparam logic [QW-1:0] OUT_HI = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] OUT_LO = {1'b1, {(QW-1){1'b0}}};

  typedef logic [2:0][CW-1:0] vec_t;

  typedef struct packed {
    logic                 deg;
    vec_t                 a;
    logic [DNW-1:0]       den;
    logic [2:0]           neg;
    logic [2:0]           sat;
    logic [2:0][RQW-1:0]  crq;
  } ctr_t;

  typedef struct packed {
    ctr_t           c;
    logic [RMW-1:0] srem;
    logic [RTW-1:0] root;
    logic [XOW-1:0] x;
  } sq_t;

  typedef struct packed {
    logic                deg;
    vec_t                a;
    logic [DNW-1:0]      den;
    logic [2:0]          neg;
    logic [2:0]          csat;
    logic [2:0][QW-1:0]  cq;
    logic                rsat;
    logic [RQW-1:0]      rrq;
  } rd_t;

  // one restoring division step, remainder and quotient share a register
  function automatic logic [RQW-1:0] div_step(input logic [RQW-1:0] rq,
                                              input logic [DNW-1:0] den);
    logic [DNW:0] t;
    logic         ge;
    t  = rq[RQW-1:QW-1];
    ge = (t >= {1'b0, den});
    if (ge) t = t - {1'b0, den};
    return {t[DNW-1:0], rq[QW-2:0], ge};
  endfunction

  // one root bit per step, optional center division step alongside
  function automatic sq_t sq_step(input sq_t s, input logic do_div);
    sq_t              r;
    logic [RMW+1:0]   t;
    logic [RMW+1:0]   tr;
    logic             ge;
    r  = s;
    t  = {s.srem, s.x[XOW-1:XOW-2]};
    tr = (RMW+2)'({s.root, 2'b01});
    ge = (t >= tr);
    if (ge) t = t - tr;
    r.srem = t[RMW-1:0];
    r.root = {s.root[RTW-2:0], ge};
    r.x    = {s.x[XOW-3:0], 2'b00};
    if (do_div) begin
      for (int k = 0; k < 3; k++) begin
        r.c.crq[k] = div_step(s.c.crq[k], s.c.den);
      end
    end
    return r;
  endfunction

  function automatic rd_t rd_init(input sq_t s);
    rd_t            r;
    logic [DNW-1:0] hi;
    hi     = DNW'(s.root[RTW-1:QW]);
    r.deg  = s.c.deg;
    r.a    = s.c.a;
    r.den  = s.c.den;
    r.neg  = s.c.neg;
    r.csat = s.c.sat;
    for (int k = 0; k < 3; k++) begin
      r.cq[k] = s.c.crq[k][QW-1:0];
    end
    r.rsat = (hi >= s.c.den);
    r.rrq  = {hi, s.root[QW-1:0]};
    return r;
  endfunction

  function automatic rd_t rd_step(input rd_t s);
    rd_t r;
    r     = s;
    r.rrq = div_step(s.rrq, s.den);
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/circ_front.sv -----
// ----------------------------------------------------------------------------
// circ_front
// Edge vectors, cross products, triple product, offset numerator N,
// center dividends and |N|^2, over nine register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module circ_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic [15:0]          in_ax,
  input  wire logic [15:0]          in_ay,
  input  wire logic [15:0]          in_az,
  input  wire logic [15:0]          in_bx,
  input  wire logic [15:0]          in_by_coord,
  input  wire logic [15:0]          in_bz,
  input  wire logic [15:0]          in_cx,
  input  wire logic [15:0]          in_cy,
  input  wire logic [15:0]          in_cz,
  input  wire logic [15:0]          in_dx,
  input  wire logic [15:0]          in_dy,
  input  wire logic [15:0]          in_dz,
  output logic                      v_out,
  output circ_pkg::sq_t             d_out
);

  localparam int CW   = circ_pkg::CW;
  localparam int EW   = circ_pkg::EW;
  localparam int XW   = circ_pkg::XW;
  localparam int LW   = circ_pkg::LW;
  localparam int DW   = circ_pkg::DW;
  localparam int DNW  = circ_pkg::DNW;
  localparam int PW   = circ_pkg::PW;
  localparam int NW   = circ_pkg::NW;
  localparam int NUMW = circ_pkg::NUMW;
  localparam int QW   = circ_pkg::QW;
  localparam int CHW  = circ_pkg::CHW;
  localparam int NCH  = circ_pkg::NCH;
  localparam int CPW  = circ_pkg::CPW;
  localparam int SQW  = circ_pkg::SQW;
  localparam int SW   = circ_pkg::SW;

  function automatic logic [XW-1:0] xterm(input logic signed [EW-1:0] p,
                                          input logic signed [EW-1:0] q,
                                          input logic signed [EW-1:0] r,
                                          input logic signed [EW-1:0] s);
    logic signed [XW-1:0] m0;
    logic signed [XW-1:0] m1;
    m0 = p * q;
    m1 = r * s;
    return m0 - m1;
  endfunction

  function automatic logic [2:0][XW-1:0] cross3(input logic [2:0][EW-1:0] u,
                                                input logic [2:0][EW-1:0] v);
    logic [2:0][XW-1:0] r;
    r[0] = xterm(u[1], v[2], u[2], v[1]);
    r[1] = xterm(u[2], v[0], u[0], v[2]);
    r[2] = xterm(u[0], v[1], u[1], v[0]);
    return r;
  endfunction

  function automatic logic [LW-1:0] len2(input logic [2:0][EW-1:0] u);
    logic signed [LW:0]   s;
    logic signed [EW-1:0] u0;
    logic signed [EW-1:0] u1;
    logic signed [EW-1:0] u2;
    u0 = u[0];
    u1 = u[1];
    u2 = u[2];
    s  = u0 * u0 + u1 * u1 + u2 * u2;
    return s[LW-1:0];
  endfunction

  function automatic logic [PW-1:0] pterm(input logic signed [XW-1:0] x,
                                          input logic [LW-1:0] l);
    logic signed [LW:0]   ls;
    logic signed [PW-1:0] p;
    ls = {1'b0, l};
    p  = x * ls;
    return p;
  endfunction

  logic [3:0][2:0][CW-1:0] pt;
  assign pt[0] = {in_az, in_ay, in_ax};
  assign pt[1] = {in_bz, in_by_coord, in_bx};
  assign pt[2] = {in_cz, in_cy, in_cx};
  assign pt[3] = {in_dz, in_dy, in_dx};

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      v4_r <= 1'b0; v5_r <= 1'b0; v6_r <= 1'b0;
      v7_r <= 1'b0; v8_r <= 1'b0; v9_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r;
      v4_r <= v3_r;     v5_r <= v4_r; v6_r <= v5_r;
      v7_r <= v6_r;     v8_r <= v7_r; v9_r <= v8_r;
    end
  end

  // stage 1: edges from the first vertex
  circ_pkg::vec_t          a1_r;
  logic [2:0][2:0][EW-1:0] e1_r, e1_nxt;

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      for (int k = 0; k < 3; k++) begin
        e1_nxt[v][k] = {pt[v+1][k][CW-1], pt[v+1][k]} - {pt[0][k][CW-1], pt[0][k]};
      end
    end
  end

  // stage 2: cross products and squared lengths
  circ_pkg::vec_t          a2_r;
  logic [2:0][EW-1:0]      e02_r;
  logic [2:0][2:0][XW-1:0] xp2_r;
  logic [2:0][LW-1:0]      ln2_r;

  // stage 3: triple product and weighted cross terms
  circ_pkg::vec_t             a3_r;
  logic signed [DW-1:0]       det3_r, det3_nxt;
  logic [2:0][2:0][PW-1:0]    pn3_r, pn3_nxt;

  always_comb begin
    det3_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      det3_nxt = det3_nxt + ($signed(e02_r[k]) * $signed(xp2_r[1][k]));
    end
    for (int k = 0; k < 3; k++) begin
      for (int m = 0; m < 3; m++) begin
        pn3_nxt[k][m] = pterm(xp2_r[m][k], ln2_r[m]);
      end
    end
  end

  // stage 4: N and |det|
  circ_pkg::vec_t      a4_r;
  logic [2:0][NW-1:0]  n4_r, n4_nxt;
  logic [DW-1:0]       adet4_r;
  logic                dneg4_r;
  logic                deg4_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n4_nxt[k] = $signed(pn3_r[k][0]) + $signed(pn3_r[k][1]) + $signed(pn3_r[k][2]);
    end
  end

  // stage 5: |N|, quotient signs, divisor
  circ_pkg::vec_t      a5_r;
  logic [2:0][NW-1:0]  nabs5_r, nabs5_nxt;
  logic [2:0]          neg5_r, neg5_nxt;
  logic [DW-1:0]       adet5_r;
  logic [DNW-1:0]      den5_r;
  logic                deg5_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nabs5_nxt[k] = n4_r[k][NW-1] ? (~n4_r[k] + 1'b1) : n4_r[k];
      neg5_nxt[k]  = n4_r[k][NW-1] ^ dneg4_r;
    end
  end

  // stage 6: center dividends, square partial products
  circ_pkg::ctr_t                    c6_r, c6_nxt;
  logic [2:0][NCH-1:0][NCH-1:0][2*CHW-1:0] pp6_r, pp6_nxt;

  always_comb begin
    logic [NUMW-1:0] num;
    logic [DNW-1:0]  hi;
    logic [CPW-1:0]  np;
    c6_nxt.deg = deg5_r;
    c6_nxt.a   = a5_r;
    c6_nxt.den = den5_r;
    c6_nxt.neg = neg5_r;
    for (int k = 0; k < 3; k++) begin
      num = (NUMW'(nabs5_r[k]) << circ_pkg::FRAC_BITS) + NUMW'(adet5_r);
      hi  = DNW'(num[NUMW-1:QW]);
      c6_nxt.sat[k] = (hi >= den5_r);
      c6_nxt.crq[k] = {hi, num[QW-1:0]};
      np = CPW'(nabs5_r[k]);
      for (int i = 0; i < NCH; i++) begin
        for (int j = 0; j < NCH; j++) begin
          pp6_nxt[k][i][j] = np[CHW*i +: CHW] * np[CHW*j +: CHW];
        end
      end
    end
  end

  // stage 7: row sums
  circ_pkg::ctr_t                c7_r;
  logic [2:0][NCH-1:0][SQW-1:0]  rw7_r, rw7_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < NCH; i++) begin
        rw7_nxt[k][i] = '0;
        for (int j = 0; j < NCH; j++) begin
          rw7_nxt[k][i] = rw7_nxt[k][i] + (SQW'(pp6_r[k][i][j]) << (CHW * j));
        end
      end
    end
  end

  // stage 8: squares
  circ_pkg::ctr_t      c8_r;
  logic [2:0][SQW-1:0] sq8_r, sq8_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq8_nxt[k] = '0;
      for (int i = 0; i < NCH; i++) begin
        sq8_nxt[k] = sq8_nxt[k] + (rw7_r[k][i] << (CHW * i));
      end
    end
  end

  // stage 9: |N|^2 into the root operand
  circ_pkg::sq_t q9_r, q9_nxt;

  always_comb begin
    logic [SW-1:0] s;
    s           = SW'(sq8_r[0]) + SW'(sq8_r[1]) + SW'(sq8_r[2]);
    q9_nxt.c    = c8_r;
    q9_nxt.srem = '0;
    q9_nxt.root = '0;
    q9_nxt.x    = circ_pkg::XOW'(s) << (2 * circ_pkg::FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r    <= pt[0];
      e1_r    <= e1_nxt;
      a2_r    <= a1_r;
      e02_r   <= e1_r[0];
      xp2_r[0] <= cross3(e1_r[0], e1_r[1]);
      xp2_r[1] <= cross3(e1_r[1], e1_r[2]);
      xp2_r[2] <= cross3(e1_r[2], e1_r[0]);
      ln2_r[0] <= len2(e1_r[2]);
      ln2_r[1] <= len2(e1_r[0]);
      ln2_r[2] <= len2(e1_r[1]);
      a3_r    <= a2_r;
      det3_r  <= det3_nxt;
      pn3_r   <= pn3_nxt;
      a4_r    <= a3_r;
      n4_r    <= n4_nxt;
      adet4_r <= det3_r[DW-1] ? (~det3_r + 1'b1) : det3_r;
      dneg4_r <= det3_r[DW-1];
      deg4_r  <= (det3_r == '0);
      a5_r    <= a4_r;
      nabs5_r <= nabs5_nxt;
      neg5_r  <= neg5_nxt;
      adet5_r <= adet4_r;
      den5_r  <= {adet4_r, 1'b0};
      deg5_r  <= deg4_r;
      c6_r    <= c6_nxt;
      pp6_r   <= pp6_nxt;
      c7_r    <= c6_r;
      rw7_r   <= rw7_nxt;
      c8_r    <= c7_r;
      sq8_r   <= sq8_nxt;
      q9_r    <= q9_nxt;
    end
  end

  assign v_out = v9_r;
  assign d_out = q9_r;

endmodule

`default_nettype wire

// ----- design/circ_iter.sv -----
// ----------------------------------------------------------------------------
// circ_iter
// Bit-per-stage square root of |N|^2, with the three center divisions in
// the first stages, then the radius division, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module circ_iter (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           v_in,
  input  wire circ_pkg::sq_t  d_in,
  output logic                v_out,
  output circ_pkg::rd_t       d_out
);

  localparam int RTW = circ_pkg::RTW;
  localparam int QW  = circ_pkg::QW;

  circ_pkg::sq_t sq_r  [RTW];
  logic          sqv_r [RTW];
  circ_pkg::rd_t ri_r;
  logic          riv_r;
  circ_pkg::rd_t rd_r  [QW];
  logic          rdv_r [QW];

  genvar i;
  for (i = 0; i < RTW; i++) begin : g_sq
    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (!rst_n) sqv_r[i] <= 1'b0;
        else if (en) sqv_r[i] <= v_in;
      end
      always_ff @(posedge clk) begin
        if (en) sq_r[i] <= circ_pkg::sq_step(d_in, 1'b1);
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (!rst_n) sqv_r[i] <= 1'b0;
        else if (en) sqv_r[i] <= sqv_r[i-1];
      end
      always_ff @(posedge clk) begin
        if (en) sq_r[i] <= circ_pkg::sq_step(sq_r[i-1], (i < QW));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) riv_r <= 1'b0;
    else if (en) riv_r <= sqv_r[RTW-1];
  end

  always_ff @(posedge clk) begin
    if (en) ri_r <= circ_pkg::rd_init(sq_r[RTW-1]);
  end

  for (i = 0; i < QW; i++) begin : g_rd
    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (!rst_n) rdv_r[i] <= 1'b0;
        else if (en) rdv_r[i] <= riv_r;
      end
      always_ff @(posedge clk) begin
        if (en) rd_r[i] <= circ_pkg::rd_step(ri_r);
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (!rst_n) rdv_r[i] <= 1'b0;
        else if (en) rdv_r[i] <= rdv_r[i-1];
      end
      always_ff @(posedge clk) begin
        if (en) rd_r[i] <= circ_pkg::rd_step(rd_r[i-1]);
      end
    end
  end

  assign v_out = rdv_r[QW-1];
  assign d_out = rd_r[QW-1];

endmodule

`default_nettype wire

// ----- design/circ_out.sv -----
// ----------------------------------------------------------------------------
// circ_out
// Center offset add, sign and saturation, degenerate override and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module circ_out (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           v_in,
  input  wire circ_pkg::rd_t  d_in,
  output logic                out_valid,
  output logic [47:0]         out_center_x,
  output logic [47:0]         out_center_y,
  output logic [47:0]         out_center_z,
  output logic [47:0]         out_radius,
  output logic                out_degenerate
);

  localparam int QW = circ_pkg::QW;
  localparam int UW = circ_pkg::UW;

  function automatic logic [QW-1:0] center(input logic [circ_pkg::CW-1:0] a,
                                           input logic [QW-1:0] q,
                                           input logic neg,
                                           input logic sat);
    logic signed [UW-1:0] base;
    logic signed [UW-1:0] qs;
    logic signed [UW-1:0] u;
    logic signed [UW-1:0] hi;
    logic signed [UW-1:0] lo;
    logic [QW-1:0]        r;
    base = UW'($signed(a)) <<< circ_pkg::FRAC_BITS;
    qs   = $signed(UW'(q));
    u    = neg ? (base - qs) : (base + qs);
    hi   = UW'($signed(circ_pkg::OUT_HI));
    lo   = UW'($signed(circ_pkg::OUT_LO));
    if (sat) r = neg ? circ_pkg::OUT_LO : circ_pkg::OUT_HI;
    else if (u > hi) r = circ_pkg::OUT_HI;
    else if (u < lo) r = circ_pkg::OUT_LO;
    else r = u[QW-1:0];
    return r;
  endfunction

  logic                ov_r;
  logic [2:0][QW-1:0]  ctr_r, ctr_nxt;
  logic [QW-1:0]       rad_r, rad_nxt;
  logic                deg_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ctr_nxt[k] = d_in.deg ? circ_pkg::OUT_HI
                            : center(d_in.a[k], d_in.cq[k], d_in.neg[k], d_in.csat[k]);
    end
    rad_nxt = (d_in.deg || d_in.rsat) ? '1 : d_in.rrq[QW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (en) ov_r <= v_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctr_r <= ctr_nxt;
      rad_r <= rad_nxt;
      deg_r <= d_in.deg;
    end
  end

  assign out_valid      = ov_r;
  assign out_center_x   = ctr_r[0];
  assign out_center_y   = ctr_r[1];
  assign out_center_z   = ctr_r[2];
  assign out_radius     = rad_r;
  assign out_degenerate = deg_r;

endmodule

`default_nettype wire

// ----- design/tetrahedron_circumsphere.sv -----
// ----------------------------------------------------------------------------
// tetrahedron_circumsphere
// Circumcenter and circumradius of a tetrahedron given by four integer
// vertices; fixed point outputs with 16 fraction bits, saturating.
//
//   channel  ports                        beat
//   in       in_valid / in_ready          four vertices, 12 coordinates
//   out      out_valid / out_ready        center x/y/z, radius, degenerate
//
// One beat per cycle sustained while the output is not stalled; the 89-step
// square root is followed by the 48-step radius division, one bit per stage.
// Synchronous active-low reset clears the valid bits only.
// The whole pipeline advances when the output register is empty or taken;
// in_ready follows that enable, so a stall holds every stage in place.
// ----------------------------------------------------------------------------
`default_nettype none

module tetrahedron_circumsphere (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [15:0]  in_ax,
  input  wire logic [15:0]  in_ay,
  input  wire logic [15:0]  in_az,
  input  wire logic [15:0]  in_bx,
  input  wire logic [15:0]  in_by_coord,
  input  wire logic [15:0]  in_bz,
  input  wire logic [15:0]  in_cx,
  input  wire logic [15:0]  in_cy,
  input  wire logic [15:0]  in_cz,
  input  wire logic [15:0]  in_dx,
  input  wire logic [15:0]  in_dy,
  input  wire logic [15:0]  in_dz,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [47:0]       out_center_x,
  output logic [47:0]       out_center_y,
  output logic [47:0]       out_center_z,
  output logic [47:0]       out_radius,
  output logic              out_degenerate
);

  logic          en;
  logic          fv;
  circ_pkg::sq_t fd;
  logic          iv;
  circ_pkg::rd_t id;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  circ_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_valid),
    .in_ax       (in_ax),
    .in_ay       (in_ay),
    .in_az       (in_az),
    .in_bx       (in_bx),
    .in_by_coord (in_by_coord),
    .in_bz       (in_bz),
    .in_cx       (in_cx),
    .in_cy       (in_cy),
    .in_cz       (in_cz),
    .in_dx       (in_dx),
    .in_dy       (in_dy),
    .in_dz       (in_dz),
    .v_out       (fv),
    .d_out       (fd)
  );

  circ_iter u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_in  (fv),
    .d_in  (fd),
    .v_out (iv),
    .d_out (id)
  );

  circ_out u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .v_in           (iv),
    .d_in           (id),
    .out_valid      (out_valid),
    .out_center_x   (out_center_x),
    .out_center_y   (out_center_y),
    .out_center_z   (out_center_z),
    .out_radius     (out_radius),
    .out_degenerate (out_degenerate)
  );

endmodule

`default_nettype wire

// ----- design/circ_chk.sv -----
// ----------------------------------------------------------------------------
// circ_chk
// Port-level checks for the circumsphere block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module circ_chk (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_valid,
  input wire logic         in_ready,
  input wire logic         out_valid,
  input wire logic         out_ready,
  input wire logic [47:0]  out_center_x,
  input wire logic [47:0]  out_center_y,
  input wire logic [47:0]  out_center_z,
  input wire logic [47:0]  out_radius,
  input wire logic         out_degenerate
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_center_x) &&
      $stable(out_radius) && $stable(out_degenerate))
    else $error("stalled output beat changed");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_flat_values: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_radius == {48{1'b1}} &&
      out_center_x == circ_pkg::OUT_HI && out_center_y == circ_pkg::OUT_HI &&
      out_center_z == circ_pkg::OUT_HI)
    else $error("flat tetrahedron beat without saturated values");

endmodule

bind tetrahedron_circumsphere circ_chk u_chk (.*);

`default_nettype wire
